@@ hdl/dpm_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the dense Prim MST block.
`timescale 1ns / 1ps
`default_nettype none
package dpm_pkg;

  localparam int MAX_V_DEF       = 64;
  localparam int WEIGHT_BITS_DEF = 32;

  // fixed port widths
  localparam int VTX_W  = 6;
  localparam int CNT_W  = 7;
  localparam int WT_IN_W = 32;

  // input word command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load_we;   // store one weight from the input word
    logic clear;     // start: empty tree, no keys, pick vertex 0
    logic take;      // move current pick into the tree
    logic upd_rd;    // relax scan: read row of pick at idx
    logic sel_init;  // reset running minimum
    logic sel_rd;    // select scan: read key at idx
    logic out_rd;    // read parent of idx
    logic out_load;  // load result register
    logic last;      // result being loaded ends the start
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic found;     // select scan hit a reachable vertex
    logic out_free;  // result register can take a word this cycle
  } stat_t;

endpackage
`default_nettype wire

@@ hdl/dense_prim_mst.sv @@
// Top level of the dense Prim minimum spanning tree block: controller plus datapath.
// Load word: one weight per cycle back to back while the block is idle (in_stall low).
// Start word: each round takes the pick, then runs a relax scan and a select scan (one vertex
//   per cycle through the registered-read key and weight stores), then results go out for
//   vertices 1..n-1; input stalls until the last result enters the result register.
// Reset (rst, synchronous, active high) clears control state and sets vertex_count
//   to 1; the weight store has no clearing pass and is undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module dense_prim_mst import dpm_pkg::*; #(
  parameter int MAX_VERTICES = MAX_V_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               command,
  input  wire logic [VTX_W-1:0]   row_vertex,
  input  wire logic [VTX_W-1:0]   column_vertex,
  input  wire logic [WT_IN_W-1:0] edge_weight,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [VTX_W-1:0]        child_vertex,
  output logic [VTX_W-1:0]        parent_vertex,
  output logic                    connected,
  output logic                    last_result,
  // vertex_count write channel
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CNT_W-1:0]   cfg_data
);

  localparam int VB = $clog2(MAX_VERTICES);

  cmd_t          cmd;
  stat_t         status;
  logic [VB-1:0] idx;   // vertex under scan, shared by every phase

  // Sequencer: round = take pick into tree, relax its row, select next minimum.
  // The search ends when every vertex is in or no reachable vertex is left.
  dpm_ctrl #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .command   (command),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd),
    .idx       (idx)
  );

  // Stores and compare logic; the result register decouples the output side so
  // loads are taken while the final result word still waits.
  dpm_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .idx           (idx),
    .row_vertex    (row_vertex),
    .column_vertex (column_vertex),
    .edge_weight   (edge_weight),
    .out_stall     (out_stall),
    .status        (status),
    .out_valid     (out_valid),
    .child_vertex  (child_vertex),
    .parent_vertex (parent_vertex),
    .connected     (connected),
    .last_result   (last_result)
  );

endmodule
`default_nettype wire

@@ hdl/dpm_datapath.sv @@
// Datapath: weight store, key and parent stores, tree flags, running minimum and result register.
`timescale 1ns / 1ps
`default_nettype none
module dpm_datapath import dpm_pkg::*; #(
  parameter int MAX_VERTICES = MAX_V_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF,
  localparam int VB = $clog2(MAX_VERTICES)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  input  wire logic [VB-1:0]      idx,
  input  wire logic [VTX_W-1:0]   row_vertex,
  input  wire logic [VTX_W-1:0]   column_vertex,
  input  wire logic [WT_IN_W-1:0] edge_weight,
  input  wire logic               out_stall,
  output stat_t                   status,
  output logic                    out_valid,
  output logic [VTX_W-1:0]        child_vertex,
  output logic [VTX_W-1:0]        parent_vertex,
  output logic                    connected,
  output logic                    last_result
);

  localparam int WDEPTH = 2 ** (2 * VB);
  localparam logic [CNT_W-1:0] V_LIM = CNT_W'(MAX_VERTICES);

  logic [WEIGHT_BITS-1:0] wmem    [WDEPTH];
  logic [WEIGHT_BITS-1:0] key_mem [MAX_VERTICES];
  logic [VB-1:0]          par_mem [MAX_VERTICES];

  logic [WEIGHT_BITS-1:0] wt_rd;
  logic [WEIGHT_BITS-1:0] key_rd;
  logic [VB-1:0]          par_rd;
  logic [WEIGHT_BITS-1:0] lowest;
  logic [VB-1:0]          pick;
  logic [VB-1:0]          idx_d;
  logic                   upd_d;
  logic                   sel_d;
  logic                   found;
  logic [MAX_VERTICES-1:0] in_tree;
  logic [MAX_VERTICES-1:0] linked;   // vertex has a finite key and a parent

  logic in_range;
  logic upd_wr;
  logic sel_hit;
  logic out_free;

  assign in_range = ({1'b0, row_vertex} < V_LIM) && ({1'b0, column_vertex} < V_LIM);

  // relax: vertex outside the tree, real edge, better than its key
  assign upd_wr = upd_d && !in_tree[idx_d] && (wt_rd != '0) &&
                  (!linked[idx_d] || (wt_rd < key_rd));
  // select: strict less keeps the lowest index on ties
  assign sel_hit = sel_d && !in_tree[idx_d] && linked[idx_d] &&
                   (!found || (key_rd < lowest));

  assign out_free = !out_valid || !out_stall;
  assign status   = '{found: found, out_free: out_free};

  always_ff @(posedge clk) begin
    if (cmd.load_we && in_range) begin
      wmem[{row_vertex[VB-1:0], column_vertex[VB-1:0]}] <= WEIGHT_BITS'(edge_weight);
    end
    wt_rd <= wmem[{pick, idx}];
  end

  always_ff @(posedge clk) begin
    if (upd_wr) begin
      key_mem[idx_d] <= wt_rd;
      par_mem[idx_d] <= pick;
    end
    key_rd <= key_mem[idx];
    if (cmd.out_rd) begin
      par_rd <= par_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    idx_d <= idx;
    if (cmd.clear) begin
      pick <= '0;
    end else if (sel_hit) begin
      pick   <= idx_d;
      lowest <= key_rd;
    end
    if (rst) begin
      upd_d   <= 1'b0;
      sel_d   <= 1'b0;
      found   <= 1'b0;
      in_tree <= '0;
      linked  <= '0;
    end else begin
      upd_d <= cmd.upd_rd;
      sel_d <= cmd.sel_rd;
      if (cmd.sel_init) begin
        found <= 1'b0;
      end else if (sel_hit) begin
        found <= 1'b1;
      end
      if (cmd.clear) begin
        in_tree <= '0;
        linked  <= '0;
      end else begin
        if (cmd.take) begin
          in_tree[pick] <= 1'b1;
        end
        if (upd_wr) begin
          linked[idx_d] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      child_vertex  <= VTX_W'(idx);
      connected     <= linked[idx];
      parent_vertex <= linked[idx] ? VTX_W'(par_rd) : '0;
      last_result   <= cmd.last;
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ hdl/dpm_ctrl.sv @@
// Controller: vertex count register, search sequencer, scan index and round counter.
`timescale 1ns / 1ps
`default_nettype none
module dpm_ctrl import dpm_pkg::*; #(
  parameter int MAX_VERTICES = MAX_V_DEF,
  localparam int VB = $clog2(MAX_VERTICES)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             command,
  output logic                  in_stall,
  input  wire logic             cfg_valid,
  input  wire logic [CNT_W-1:0] cfg_data,
  output logic                  cfg_ready,
  input  wire stat_t            status,
  output cmd_t                  cmd,
  output logic [VB-1:0]         idx
);

  localparam int CB = $clog2(MAX_VERTICES + 1);
  localparam logic [CNT_W-1:0] V_LIM = CNT_W'(MAX_VERTICES);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_TAKE    = 4'd1;
  localparam logic [3:0] S_UPD     = 4'd2;
  localparam logic [3:0] S_UPD_END = 4'd3;
  localparam logic [3:0] S_SEL     = 4'd4;
  localparam logic [3:0] S_SEL_END = 4'd5;
  localparam logic [3:0] S_SEL_DEC = 4'd6;
  localparam logic [3:0] S_OUT_RD  = 4'd7;
  localparam logic [3:0] S_OUT_WR  = 4'd8;

  logic [3:0]       state, state_next;
  logic [VB-1:0]    idx_next;
  logic [CB-1:0]    rounds_done, rounds_done_next;
  logic [CB-1:0]    n_run, n_run_next;
  logic [CNT_W-1:0] vertex_count;
  logic [CB-1:0]    n_cfg;
  logic             idx_last;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  // clamp count into 1..MAX_VERTICES
  always_comb begin
    priority if (vertex_count == '0) begin
      n_cfg = CB'(1);
    end else if (vertex_count > V_LIM) begin
      n_cfg = CB'(MAX_VERTICES);
    end else begin
      n_cfg = CB'(vertex_count);
    end
  end

  assign idx_last = (CB'(idx) == (n_run - CB'(1)));

  always_comb begin
    cmd              = '0;
    state_next       = state;
    idx_next         = idx;
    rounds_done_next = rounds_done;
    n_run_next       = n_run;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (command == CMD_START) begin
            cmd.clear        = 1'b1;
            rounds_done_next = '0;
            n_run_next       = n_cfg;
            state_next       = S_TAKE;
          end else begin
            cmd.load_we = 1'b1;
          end
        end
      end
      S_TAKE: begin
        cmd.take         = 1'b1;
        rounds_done_next = rounds_done + CB'(1);
        idx_next         = '0;
        state_next       = S_UPD;
      end
      S_UPD: begin
        cmd.upd_rd = 1'b1;
        if (idx_last) begin
          state_next = S_UPD_END;
        end else begin
          idx_next = idx + VB'(1);
        end
      end
      S_UPD_END: begin
        if (rounds_done == n_run) begin
          if (n_run == CB'(1)) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = VB'(1);
            state_next = S_OUT_RD;
          end
        end else begin
          cmd.sel_init = 1'b1;
          idx_next     = '0;
          state_next   = S_SEL;
        end
      end
      S_SEL: begin
        cmd.sel_rd = 1'b1;
        if (idx_last) begin
          state_next = S_SEL_END;
        end else begin
          idx_next = idx + VB'(1);
        end
      end
      S_SEL_END: begin
        state_next = S_SEL_DEC;
      end
      S_SEL_DEC: begin
        if (status.found) begin
          state_next = S_TAKE;
        end else begin
          // n_run >= 2 here: a one vertex run ends at its first relax pass
          idx_next   = VB'(1);
          state_next = S_OUT_RD;
        end
      end
      S_OUT_RD: begin
        cmd.out_rd = 1'b1;
        state_next = S_OUT_WR;
      end
      S_OUT_WR: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.last     = idx_last;
          if (idx_last) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + VB'(1);
            state_next = S_OUT_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    idx   <= idx_next;
    n_run <= n_run_next;
    if (rst) begin
      state        <= S_IDLE;
      rounds_done  <= '0;
      vertex_count <= CNT_W'(1);
    end else begin
      state       <= state_next;
      rounds_done <= rounds_done_next;
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end
    end
  end

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !(in_valid && command == CMD_START)) |=> (state == S_IDLE))
    else $error("left idle without a start word");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD || state == S_SEL) |-> (CB'(idx) < n_run))
    else $error("scan index past vertex count");

  a_take_rounds: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> (rounds_done < n_run))
    else $error("more rounds than vertices");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result register overwritten while stalled");

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the dense Prim minimum spanning tree block.
`timescale 1ns / 1ps
module tb_top;
  import dpm_pkg::*;

  localparam int NV = MAX_V_DEF;
  // Key value above every 32-bit weight: an unreached vertex
  localparam logic [32:0] KEY_INF = 33'h1_0000_0000;
  localparam int RESET_CYCLES = 12;
  // Long enough for a 64-vertex search with margin
  localparam int WATCHDOG_LIMIT = 40000;
  // Quiet time before a register write and at the end; covers a start that
  // emits nothing (one vertex) and the tail of the controller
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_WORDS = 236;

  // One result word as the block should hand it out
  typedef struct {
    logic [VTX_W-1:0] child;
    logic [VTX_W-1:0] parent;
    logic             connected;
    logic             last;
  } tree_edge_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               command = CMD_LOAD;
  logic [VTX_W-1:0]   row_vertex = '0;
  logic [VTX_W-1:0]   column_vertex = '0;
  logic [WT_IN_W-1:0] edge_weight = '0;
  logic               out_stall = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [CNT_W-1:0]   cfg_data = '0;
  wire                in_stall;
  wire                out_valid;
  wire [VTX_W-1:0]    child_vertex;
  wire [VTX_W-1:0]    parent_vertex;
  wire                connected;
  wire                last_result;
  wire                cfg_ready;

  // Predictor state: a mirror of the weight matrix and of vertex_count
  logic [WT_IN_W-1:0] weight_mirror [NV][NV];
  logic [CNT_W-1:0]   vertex_count_mirror = 7'd1;

  // Tree edges still owed by the block, oldest first
  tree_edge_t expected_edges [$];

  int fail_count = 0;
  int words_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  dense_prim_mst u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .row_vertex    (row_vertex),
    .column_vertex (column_vertex),
    .edge_weight   (edge_weight),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .child_vertex  (child_vertex),
    .parent_vertex (parent_vertex),
    .connected     (connected),
    .last_result   (last_result),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  // Receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Register value 0 acts as one vertex, anything above 64 as 64
  function automatic int active_vertices(input logic [CNT_W-1:0] count);
    if (count == 0) return 1;
    if (count > NV) return NV;
    return int'(count);
  endfunction

  // Prim from vertex 0 over the mirrored matrix; edge u->v is row u, column v.
  // Zero means no edge, strict compares give ties to the lowest index, and the
  // search quits once no unreached vertex has a finite key.
  function automatic void predict_spanning_tree(input int n);
    logic [32:0] key [NV];
    int          parent [NV];
    bit          taken [NV];
    logic [32:0] lowest;
    logic [32:0] w;
    int          pick;
    bit          found;
    bit          done;
    tree_edge_t  te;
    for (int v = 0; v < NV; v++) begin
      key[v] = KEY_INF;
      parent[v] = -1;
      taken[v] = 1'b0;
    end
    key[0] = '0;
    done = 1'b0;
    for (int r = 0; r < n && !done; r++) begin
      lowest = KEY_INF;
      found = 1'b0;
      pick = 0;
      for (int v = 0; v < n; v++) begin
        if (!taken[v] && key[v] < lowest) begin
          lowest = key[v];
          pick = v;
          found = 1'b1;
        end
      end
      if (!found) begin
        done = 1'b1;
      end else begin
        taken[pick] = 1'b1;
        for (int v = 0; v < n; v++) begin
          w = {1'b0, weight_mirror[pick][v]};
          if (!taken[v] && w != 0 && w < key[v]) begin
            key[v] = w;
            parent[v] = pick;
          end
        end
      end
    end
    for (int v = 1; v < n; v++) begin
      te.child = v[VTX_W-1:0];
      te.connected = (parent[v] >= 0);
      te.parent = te.connected ? parent[v][VTX_W-1:0] : '0;
      te.last = (v == n - 1);
      expected_edges.push_back(te);
    end
  endfunction

  // Mix of no-edge, tie-prone small values, both extremes and full-range values
  function automatic logic [WT_IN_W-1:0] random_weight();
    case ($urandom_range(9))
      0, 1:    return '0;
      2, 3:    return WT_IN_W'($urandom_range(1, 4));
      4:       return '1;
      5:       return WT_IN_W'(1);
      default: return $urandom();
    endcase
  endfunction

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    send_idle_pct = sender_pct;
    recv_stall_pct = receiver_pct;
  endtask

  // Drive one input word and hold it until the block takes it. Valid stays
  // high on return so the next call can follow back to back; anything else
  // that follows must lower it first.
  task automatic send_word(input logic cmd, input logic [VTX_W-1:0] r,
                           input logic [VTX_W-1:0] c, input logic [WT_IN_W-1:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    row_vertex <= r;
    column_vertex <= c;
    edge_weight <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (cmd == CMD_LOAD) begin
      weight_mirror[r][c] = w;
    end else begin
      predict_spanning_tree(active_vertices(vertex_count_mirror));
    end
  endtask

  task automatic send_start();
    send_word(CMD_START, VTX_W'($urandom_range(63)), VTX_W'($urandom_range(63)), $urandom());
  endtask

  // Fill rows and columns 0..n-1 so that a start never reads an unwritten entry
  task automatic load_square(input int n);
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) send_word(CMD_LOAD, VTX_W'(r), VTX_W'(c), random_weight());
    end
  endtask

  // Lower valid, then wait for every owed word
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_edges.size() != 0) @(posedge clk);
  endtask

  // Register writes only with the block idle: drain, then let a start that
  // produces no word run out
  task automatic write_vertex_count(input logic [CNT_W-1:0] count);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= count;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    vertex_count_mirror = count;
  endtask

  // Result checker: every accepted word is matched against the oldest expectation
  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin : check_result
      tree_edge_t want;
      if (expected_edges.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected word, expected none, actual child %0d parent %0d",
                 $time, child_vertex, parent_vertex);
        $display("%0t: unexpected word, actual conn %0d last %0d",
                 $time, connected, last_result);
      end else begin
        want = expected_edges.pop_front();
        compare_field("child_vertex", int'(want.child), int'(child_vertex));
        compare_field("parent_vertex", int'(want.parent), int'(parent_vertex));
        compare_field("connected", int'(want.connected), int'(connected));
        compare_field("last_result", int'(want.last), int'(last_result));
      end
    end
  end

  // Watchdog: too long without any handshake on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("[dense_prim_mst] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One vertex, both as the reset count and as register value zero: no words
  task automatic test_single_vertex();
    send_word(CMD_LOAD, '0, '0, '0);
    send_start();
    write_vertex_count('0);
    send_word(CMD_LOAD, '0, '0, '1);
    send_start();
  endtask

  // Four vertices: a key tie settled by index, a parent change, an edge back
  // into the tree, and a vertex with no incoming edge that never joins.
  // Then two loads reach that vertex with equal weights from different parents.
  task automatic test_ties_and_unreached();
    logic [WT_IN_W-1:0] pattern [4][4];
    pattern = '{'{32'd0, 32'd7, 32'd7, 32'd0},
                '{32'd0, 32'd0, 32'd3, 32'd0},
                '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0},
                '{32'd1, 32'd1, 32'd1, 32'd1}};
    write_vertex_count(CNT_W'(4));
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) send_word(CMD_LOAD, VTX_W'(r), VTX_W'(c), pattern[r][c]);
    end
    send_start();
    send_word(CMD_LOAD, VTX_W'(2), VTX_W'(3), 32'd1);
    send_word(CMD_LOAD, VTX_W'(1), VTX_W'(3), 32'd1);
    send_start();
  endtask

  // Random graphs: set a count, load the square, then a few starts with some
  // weights changed in between. Stray loads land anywhere in the matrix.
  // The idle profile steps through its three settings as words go out.
  task automatic test_random_graphs(input int target);
    int base;
    int n;
    logic [CNT_W-1:0] count;
    base = words_sent;
    while (words_sent - base < target) begin
      if (words_sent - base < target / 3) set_idling(6, 83);
      else if (words_sent - base < 2 * target / 3) set_idling(83, 6);
      else set_idling(0, 0);
      case ($urandom_range(9))
        0:       count = 7'd0;
        1:       count = 7'd1;
        2:       count = CNT_W'($urandom_range(8, 12));
        default: count = CNT_W'($urandom_range(2, 7));
      endcase
      n = active_vertices(count);
      // shrink the last graph so the word total stays near the target
      while (n > 2 && words_sent - base + n * n > target) begin
        n--;
        count = CNT_W'(n);
      end
      write_vertex_count(count);
      repeat ($urandom_range(0, 2))
        send_word(CMD_LOAD, VTX_W'($urandom_range(63)), VTX_W'($urandom_range(63)),
                  random_weight());
      load_square(n);
      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(0, 3))
          send_word(CMD_LOAD, VTX_W'($urandom_range(n - 1)), VTX_W'($urandom_range(n - 1)),
                    random_weight());
        send_start();
        // now and then hold off until the tree is fully out
        if ($urandom_range(3) == 0) drain_results();
      end
    end
  endtask

  initial begin
    set_idling(6, 83);
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_single_vertex();
    test_ties_and_unreached();
    test_random_graphs(RANDOM_WORDS);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[dense_prim_mst] OK");
    end else begin
      $display("[dense_prim_mst] ERROR");
    end
    $finish;
  end

endmodule
